@@ sv/tlpr_pkg.sv @@
// Shared constants, types and helpers for the triangle lattice point rasterizer.
// Used by the top level, by its port checker and by the testbench; depends on nothing.
`default_nettype none

package tlpr_pkg;

  // field widths
  localparam int CORNER_W = 32;
  localparam int FACE_W   = 24;
  localparam int POINT_W  = 16;
  localparam int WEIGHT_W = 17;
  localparam int WFRAC_W  = 16;
  localparam int WBIT_W   = $clog2(WFRAC_W);

  // stream packing
  localparam int S_TDATA_W = 216;
  localparam int M_TDATA_W = 112;
  localparam int PU_LSB    = 0;
  localparam int PV_LSB    = PU_LSB + POINT_W;
  localparam int FACE_LSB  = PV_LSB + POINT_W;
  localparam int W0_LSB    = FACE_LSB + FACE_W;
  localparam int W1_LSB    = W0_LSB + WEIGHT_W;
  localparam int W2_LSB    = W1_LSB + WEIGHT_W;
  localparam int PAD_W     = M_TDATA_W - (W2_LSB + WEIGHT_W);

  // datapath widths: multiplier operand, edge accumulator, magnitude
  localparam int MUL_W = CORNER_W + 1;
  localparam int AW    = 70;
  localparam int DW    = 67;

  // setup sequence: products per triangle
  localparam int NSTEP  = 14;
  localparam int STEP_W = $clog2(NSTEP);

  // accumulator destination codes
  localparam logic [1:0] DST_AREA = 2'd0;
  localparam logic [1:0] DST_E0   = 2'd1;
  localparam logic [1:0] DST_E1   = 2'd2;
  localparam logic [1:0] DST_E2   = 2'd3;

  typedef struct packed {
    logic       neg;    // subtract the product
    logic       shl;    // scale product by the lattice pitch
    logic       first;  // start a new sum
    logic       last;   // sum complete, store it
    logic [1:0] dst;
  } mul_op_t;

  function automatic logic signed [MUL_W-1:0] sext_c(input logic signed [CORNER_W-1:0] x);
    return {x[CORNER_W-1], x};
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] a;
    a = x[AW-1] ? -x : x;
    return a[DW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/triangle_lattice_point_rasterizer_top.sv @@
// Triangle lattice point rasterizer: scans the lattice points of one triangle's box
// and gives each inside point with its three barycentric weights. Uses tlpr_pkg.
// An unselected triangle is accepted and dropped. A selected one goes through setup (box,
// 14 products through one shared multiplier, area check), then a scan of the candidates,
// a restoring divider (one bit a cycle) for the weights of each inside point, and a move of
// each result to the output register. Throughput: one triangle at a time, not ready until
// its last result, if any, is registered. Async active-low reset returns to idle, empty.
`default_nettype none

module triangle_lattice_point_rasterizer_top #(
  parameter int SPAN      = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // corner_u0, corner_v0, corner_u1, corner_v1, corner_u2, corner_v2, face_id
  input  logic [tlpr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // selected
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // point_u, point_v, face_out, weight0, weight1, weight2, zero pad
  output logic [tlpr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // last_point
  output logic                             m_axis_tlast,
  // clipped
  output logic                             m_axis_tuser
);
  import tlpr_pkg::*;

  localparam int LW = MUL_W - FRAC_BITS;   // lattice coordinate width
  localparam int CW = $clog2(SPAN + 1);
  localparam int PW = LW + POINT_W;

  localparam logic signed [MUL_W-1:0] RND     = MUL_W'((64'(1) << FRAC_BITS) - 64'(1));
  localparam logic signed [LW:0]      LAT_ONE = (LW+1)'(1);
  localparam logic signed [LW:0]      SPAN_L  = (LW+1)'(SPAN);
  localparam logic [CW-1:0]           SPAN_M1 = CW'(SPAN - 1);
  localparam logic [STEP_W-1:0]       STEP_LAST = STEP_W'(NSTEP - 1);
  localparam logic [WBIT_W-1:0]       BIT_LAST  = WBIT_W'(WFRAC_W - 1);
  localparam logic [1:0]              K_FIRST = 2'd0;
  localparam logic [1:0]              K_MID   = 2'd1;
  localparam logic [1:0]              K_LAST  = 2'd2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BOX   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;
  localparam logic [2:0] ST_FLUSH = 3'd7;

  function automatic logic signed [LW-1:0] floor_lat(input logic signed [CORNER_W-1:0] x);
    logic signed [MUL_W-1:0] t;
    t = sext_c(x) >>> FRAC_BITS;
    return t[LW-1:0];
  endfunction

  function automatic logic signed [LW-1:0] ceil_lat(input logic signed [CORNER_W-1:0] x);
    logic signed [MUL_W-1:0] t;
    t = (sext_c(x) + RND) >>> FRAC_BITS;
    return t[LW-1:0];
  endfunction

  function automatic logic signed [CORNER_W-1:0] min3(input logic signed [CORNER_W-1:0] a,
                                                     input logic signed [CORNER_W-1:0] b,
                                                     input logic signed [CORNER_W-1:0] c);
    logic signed [CORNER_W-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [CORNER_W-1:0] max3(input logic signed [CORNER_W-1:0] a,
                                                     input logic signed [CORNER_W-1:0] b,
                                                     input logic signed [CORNER_W-1:0] c);
    logic signed [CORNER_W-1:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  // control
  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic              acc_en_q;
  mul_op_t           op_q, op;
  logic [CW-1:0]     iu_q, iv_q, ulast_q, vlast_q;
  logic              empty_q, clip_q;
  logic [1:0]        dk_q;
  logic [WBIT_W-1:0] bit_q;
  logic              pend_valid_q;
  logic              m_tvalid_q;

  // payload
  logic signed [CORNER_W-1:0] cu0_q, cv0_q, cu1_q, cv1_q, cu2_q, cv2_q;
  logic [FACE_W-1:0]          face_q;
  logic signed [LW-1:0]       umin_q, vmin_q;
  logic signed [2*MUL_W-1:0]  mul_q;
  logic signed [AW-1:0]       acc_q, area_q;
  logic signed [AW-1:0]       e_q [3];
  logic signed [AW-1:0]       erow_q [3];
  logic [DW-1:0]              aabs_q, rem_q;
  logic [WFRAC_W-1:0]         quo_q;
  logic [WFRAC_W-1:0]         wt_q [3];
  logic [POINT_W-1:0]         pend_u_q, pend_v_q;
  logic [M_TDATA_W-1:0]       out_data_q;
  logic                       out_last_q, out_user_q;

  // combinational
  logic signed [MUL_W-1:0] du0, dv0, du1, dv1, du2, dv2, e02u, e02v;
  logic signed [MUL_W-1:0] umin_x, vmin_x, op_a, op_b;
  logic signed [AW-1:0]    dus [3];
  logic signed [AW-1:0]    dvs [3];
  logic signed [AW-1:0]    prod_ext, prod_sh, acc_nxt;
  logic signed [LW-1:0]    bu_min, bu_max, bv_min, bv_max;
  logic signed [LW:0]      nu_w, nv_w, nu_m1, nv_m1;
  logic [2:0]              lane_in;
  logic                    pt_in, final_pt, slot_free, in_take, div_done, div_start, adv;
  logic [DW:0]             dtwo;
  logic                    dge;
  logic [DW-1:0]           rem_d;
  logic [WFRAC_W-1:0]      quo_d;
  logic signed [AW-1:0]    next_e;
  logic signed [PW-1:0]    pu_full, pv_full;

  assign du0  = sext_c(cu2_q) - sext_c(cu1_q);
  assign dv0  = sext_c(cv2_q) - sext_c(cv1_q);
  assign du1  = sext_c(cu0_q) - sext_c(cu2_q);
  assign dv1  = sext_c(cv0_q) - sext_c(cv2_q);
  assign du2  = sext_c(cu1_q) - sext_c(cu0_q);
  assign dv2  = sext_c(cv1_q) - sext_c(cv0_q);
  assign e02u = sext_c(cu2_q) - sext_c(cu0_q);
  assign e02v = sext_c(cv2_q) - sext_c(cv0_q);

  assign umin_x = {{(MUL_W-LW){umin_q[LW-1]}}, umin_q};
  assign vmin_x = {{(MUL_W-LW){vmin_q[LW-1]}}, vmin_q};

  // per-lane lattice steps: one v step adds du, one u step subtracts dv
  assign dus[0] = {{(AW-MUL_W){du0[MUL_W-1]}}, du0} <<< FRAC_BITS;
  assign dus[1] = {{(AW-MUL_W){du1[MUL_W-1]}}, du1} <<< FRAC_BITS;
  assign dus[2] = {{(AW-MUL_W){du2[MUL_W-1]}}, du2} <<< FRAC_BITS;
  assign dvs[0] = {{(AW-MUL_W){dv0[MUL_W-1]}}, dv0} <<< FRAC_BITS;
  assign dvs[1] = {{(AW-MUL_W){dv1[MUL_W-1]}}, dv1} <<< FRAC_BITS;
  assign dvs[2] = {{(AW-MUL_W){dv2[MUL_W-1]}}, dv2} <<< FRAC_BITS;

  // bounding box in lattice units
  assign bu_min = ceil_lat(min3(cu0_q, cu1_q, cu2_q));
  assign bu_max = floor_lat(max3(cu0_q, cu1_q, cu2_q));
  assign bv_min = ceil_lat(min3(cv0_q, cv1_q, cv2_q));
  assign bv_max = floor_lat(max3(cv0_q, cv1_q, cv2_q));
  assign nu_w   = {bu_max[LW-1], bu_max} - {bu_min[LW-1], bu_min} + LAT_ONE;
  assign nv_w   = {bv_max[LW-1], bv_max} - {bv_min[LW-1], bv_min} + LAT_ONE;
  assign nu_m1  = nu_w - LAT_ONE;
  assign nv_m1  = nv_w - LAT_ONE;

  // setup products: area, then a x b + (b - a) x p0 for each edge
  always_comb begin
    op   = '0;
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      4'd0:  begin op_a = du2;           op_b = e02v;          op = '{1'b0, 1'b0, 1'b1, 1'b0, DST_AREA}; end
      4'd1:  begin op_a = dv2;           op_b = e02u;          op = '{1'b1, 1'b0, 1'b0, 1'b1, DST_AREA}; end
      4'd2:  begin op_a = sext_c(cu1_q); op_b = sext_c(cv2_q); op = '{1'b0, 1'b0, 1'b1, 1'b0, DST_E0}; end
      4'd3:  begin op_a = sext_c(cv1_q); op_b = sext_c(cu2_q); op = '{1'b1, 1'b0, 1'b0, 1'b0, DST_E0}; end
      4'd4:  begin op_a = du0;           op_b = vmin_x;        op = '{1'b0, 1'b1, 1'b0, 1'b0, DST_E0}; end
      4'd5:  begin op_a = dv0;           op_b = umin_x;        op = '{1'b1, 1'b1, 1'b0, 1'b1, DST_E0}; end
      4'd6:  begin op_a = sext_c(cu2_q); op_b = sext_c(cv0_q); op = '{1'b0, 1'b0, 1'b1, 1'b0, DST_E1}; end
      4'd7:  begin op_a = sext_c(cv2_q); op_b = sext_c(cu0_q); op = '{1'b1, 1'b0, 1'b0, 1'b0, DST_E1}; end
      4'd8:  begin op_a = du1;           op_b = vmin_x;        op = '{1'b0, 1'b1, 1'b0, 1'b0, DST_E1}; end
      4'd9:  begin op_a = dv1;           op_b = umin_x;        op = '{1'b1, 1'b1, 1'b0, 1'b1, DST_E1}; end
      4'd10: begin op_a = sext_c(cu0_q); op_b = sext_c(cv1_q); op = '{1'b0, 1'b0, 1'b1, 1'b0, DST_E2}; end
      4'd11: begin op_a = sext_c(cv0_q); op_b = sext_c(cu1_q); op = '{1'b1, 1'b0, 1'b0, 1'b0, DST_E2}; end
      4'd12: begin op_a = du2;           op_b = vmin_x;        op = '{1'b0, 1'b1, 1'b0, 1'b0, DST_E2}; end
      4'd13: begin op_a = dv2;           op_b = umin_x;        op = '{1'b1, 1'b1, 1'b0, 1'b1, DST_E2}; end
      default: begin op = '0; op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_ext = {{(AW-2*MUL_W){mul_q[2*MUL_W-1]}}, mul_q};
  assign prod_sh  = op_q.shl ? (prod_ext <<< FRAC_BITS) : prod_ext;
  assign acc_nxt  = (op_q.first ? '0 : acc_q) + (op_q.neg ? -prod_sh : prod_sh);

  // strictly inside: every edge value nonzero with the sign of the area
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_in[k] = (e_q[k] != '0) && (e_q[k][AW-1] == area_q[AW-1]);
    end
  end
  assign pt_in    = &lane_in;
  assign final_pt = (iu_q == ulast_q) && (iv_q == vlast_q);

  // restoring divider step
  assign dtwo  = {rem_q, 1'b0};
  assign dge   = dtwo >= {1'b0, aabs_q};
  assign rem_d = dge ? DW'(dtwo - {1'b0, aabs_q}) : dtwo[DW-1:0];
  assign quo_d = {quo_q[WFRAC_W-2:0], dge};

  always_comb begin
    unique case (dk_q)
      K_FIRST: next_e = e_q[1];
      K_MID:   next_e = e_q[2];
      default: next_e = e_q[0];
    endcase
  end

  assign pu_full = {{POINT_W{umin_q[LW-1]}}, umin_q} + {{(PW-CW){1'b0}}, iu_q};
  assign pv_full = {{POINT_W{vmin_q[LW-1]}}, vmin_q} + {{(PW-CW){1'b0}}, iv_q};

  assign slot_free = !m_tvalid_q || m_axis_tready;
  assign in_take   = s_axis_tvalid && (state_q == ST_IDLE);
  assign div_done  = (state_q == ST_DIV) && (bit_q == BIT_LAST) && (dk_q == K_LAST);
  assign div_start = (state_d == ST_DIV) && (state_q != ST_DIV);
  assign adv       = ((state_q == ST_SCAN) && !pt_in) || div_done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_take && s_axis_tuser) state_d = ST_BOX;
      ST_BOX:   state_d = ST_MUL;
      ST_MUL:   if (step_q == STEP_LAST) state_d = ST_CHK;
      ST_CHK:   state_d = ((area_q == '0) || empty_q) ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (pt_in) begin
          state_d = pend_valid_q ? ST_EMIT : ST_DIV;
        end else if (final_pt) begin
          state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_DIV:   if (div_done) state_d = final_pt ? ST_FLUSH : ST_SCAN;
      ST_EMIT:  if (slot_free) state_d = ST_DIV;
      ST_FLUSH: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      acc_en_q     <= 1'b0;
      op_q         <= '0;
      iu_q         <= '0;
      iv_q         <= '0;
      dk_q         <= K_FIRST;
      bit_q        <= '0;
      pend_valid_q <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= (state_q == ST_MUL);
      op_q     <= op;

      if (state_q == ST_BOX) begin
        step_q <= '0;
      end else if (state_q == ST_MUL) begin
        step_q <= step_q + STEP_W'(1);
      end

      if (state_q == ST_CHK) begin
        iu_q <= '0;
        iv_q <= '0;
      end else if (adv) begin
        if (iv_q != vlast_q) begin
          iv_q <= iv_q + CW'(1);
        end else begin
          iv_q <= '0;
          iu_q <= iu_q + CW'(1);
        end
      end

      if (div_start) begin
        dk_q  <= K_FIRST;
        bit_q <= '0;
      end else if (state_q == ST_DIV) begin
        if (bit_q == BIT_LAST) begin
          bit_q <= '0;
          dk_q  <= dk_q + 2'd1;
        end else begin
          bit_q <= bit_q + WBIT_W'(1);
        end
      end

      if (div_done) begin
        pend_valid_q <= 1'b1;
      end else if (((state_q == ST_EMIT) || (state_q == ST_FLUSH)) && slot_free) begin
        pend_valid_q <= 1'b0;
      end

      if (((state_q == ST_EMIT) || (state_q == ST_FLUSH)) && slot_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cu0_q  <= s_axis_tdata[31:0];
      cv0_q  <= s_axis_tdata[63:32];
      cu1_q  <= s_axis_tdata[95:64];
      cv1_q  <= s_axis_tdata[127:96];
      cu2_q  <= s_axis_tdata[159:128];
      cv2_q  <= s_axis_tdata[191:160];
      face_q <= s_axis_tdata[215:192];
    end

    if (state_q == ST_BOX) begin
      umin_q  <= bu_min;
      vmin_q  <= bv_min;
      empty_q <= (nu_w < LAT_ONE) || (nv_w < LAT_ONE);
      clip_q  <= (nu_w > SPAN_L) || (nv_w > SPAN_L);
      ulast_q <= (nu_w > SPAN_L) ? SPAN_M1 : nu_m1[CW-1:0];
      vlast_q <= (nv_w > SPAN_L) ? SPAN_M1 : nv_m1[CW-1:0];
    end

    mul_q <= op_a * op_b;

    if (acc_en_q) begin
      acc_q <= acc_nxt;
      if (op_q.last) begin
        if (op_q.dst == DST_AREA) area_q <= acc_nxt;
        if (op_q.dst == DST_E0) begin e_q[0] <= acc_nxt; erow_q[0] <= acc_nxt; end
        if (op_q.dst == DST_E1) begin e_q[1] <= acc_nxt; erow_q[1] <= acc_nxt; end
        if (op_q.dst == DST_E2) begin e_q[2] <= acc_nxt; erow_q[2] <= acc_nxt; end
      end
    end

    if (state_q == ST_CHK) begin
      aabs_q <= mag(area_q);
    end

    // edge values follow the scan: v inner, u outer from the row start
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (iv_q != vlast_q) begin
          e_q[k] <= e_q[k] + dus[k];
        end else begin
          e_q[k]    <= erow_q[k] - dvs[k];
          erow_q[k] <= erow_q[k] - dvs[k];
        end
      end
    end

    if (div_start) begin
      rem_q <= mag(e_q[0]);
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      if (bit_q == BIT_LAST) begin
        wt_q[dk_q] <= quo_d;
        rem_q      <= mag(next_e);
      end else begin
        rem_q <= rem_d;
      end
      quo_q <= quo_d;
    end

    if (div_done) begin
      pend_u_q <= pu_full[POINT_W-1:0];
      pend_v_q <= pv_full[POINT_W-1:0];
    end

    if (((state_q == ST_EMIT) || (state_q == ST_FLUSH)) && slot_free) begin
      out_data_q <= {{PAD_W{1'b0}},
                     1'b0, wt_q[2], 1'b0, wt_q[1], 1'b0, wt_q[0],
                     face_q, pend_v_q, pend_u_q};
      out_last_q <= (state_q == ST_FLUSH);
      out_user_q <= clip_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

@@ sv/tlpr_checker.sv @@
// Port-level checks for the triangle lattice point rasterizer, bound to its top level.
// Uses tlpr_pkg for the result packing.
`default_nettype none

module tlpr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tlpr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,
  input  logic                           m_axis_tuser
);
  import tlpr_pkg::*;

  localparam logic [WEIGHT_W+1:0] W_ONE = (WEIGHT_W+2)'(1 << WFRAC_W);

  logic [WEIGHT_W+1:0] wsum;

  assign wsum = (WEIGHT_W+2)'(m_axis_tdata[W0_LSB +: WEIGHT_W])
              + (WEIGHT_W+2)'(m_axis_tdata[W1_LSB +: WEIGHT_W])
              + (WEIGHT_W+2)'(m_axis_tdata[W2_LSB +: WEIGHT_W]);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a selected triangle occupies the block
  a_sel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("ready after a selected request");

  // an unselected triangle is dropped at once
  a_unsel_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("not ready after an unselected request");

  // truncated weights never sum past one
  a_wsum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> wsum <= W_ONE)
    else $error("weight sum above one");

endmodule

bind triangle_lattice_point_rasterizer_top tlpr_checker u_tlpr_checker (.*);

`default_nettype wire

@@ verif/triangle_lattice_point_rasterizer_top_tb.sv @@
// Self-checking stream testbench for triangle_lattice_point_rasterizer_top.
// Predicts lattice points and weights in 128-bit integer arithmetic, or takes them from
// the directed table, and compares in order. Depends on tlpr_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module triangle_lattice_point_rasterizer_top_tb;

  localparam int  SPAN         = 8;
  localparam int  FRAC_BITS    = 16;
  localparam int  UNIT         = 1 << FRAC_BITS;
  localparam int  RANDOM_ITEMS = 430;
  localparam int  HOLD_CYCLES  = 2000;
  localparam int  STALL_LIMIT  = 20000;
  localparam int  DRAIN_CYCLES = 1000;

  // same layout as s_axis_tdata, corner_u0 lowest
  typedef struct packed {
    logic [23:0] face_id;
    logic [31:0] cv2, cu2, cv1, cu1, cv0, cu0;
  } corners_t;

  // same layout as m_axis_tdata, point_u lowest
  typedef struct packed {
    logic [4:0]  pad;
    logic [16:0] w2, w1, w0;
    logic [23:0] face;
    logic [15:0] pv, pu;
  } hit_data_t;

  typedef struct {
    hit_data_t data;
    bit        clipped;
    bit        last;
  } lattice_hit_t;

  typedef enum {ROW_MODEL, ROW_NONE, ROW_ONE} row_kind_e;

  typedef struct {
    corners_t     c;
    bit           sel;
    row_kind_e    kind;
    lattice_hit_t hit;
  } dir_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [tlpr_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [tlpr_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic                             m_axis_tlast;
  logic                             m_axis_tuser;

  lattice_hit_t pending_hits[$];
  dir_row_t     dir_rows[$];
  int           mismatches = 0;
  int           n_offered = 0;
  int           n_scanned = 0;
  int           n_points = 0;
  int           n_clipped = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  bit           hold_req = 1'b0;
  bit           hold_taken = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  triangle_lattice_point_rasterizer_top #(
    .SPAN      (SPAN),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [127:0] cross_uv(input longint ax, input longint ay,
                                                   input longint bx, input longint by);
    logic signed [127:0] xa, ya, xb, yb;
    xa = ax;
    ya = ay;
    xb = bx;
    yb = by;
    return xa * yb - ya * xb;
  endfunction

  // appends the expected lattice points of one accepted triangle
  function automatic void raster_hits(input corners_t c, input bit sel);
    longint              cu[3], cv[3];
    longint              umin, umax, vmin, vmax, nu, nv, u, v, pu, pv;
    logic signed [127:0] area, sub;
    logic [127:0]        aabs, smag;
    logic [16:0]         wt[3];
    int                  k, a, b;
    bit                  clip, pt_in, pos;
    lattice_hit_t        h;
    lattice_hit_t        found[$];
    cu[0] = $signed(c.cu0);
    cv[0] = $signed(c.cv0);
    cu[1] = $signed(c.cu1);
    cv[1] = $signed(c.cv1);
    cu[2] = $signed(c.cu2);
    cv[2] = $signed(c.cv2);
    if (!sel) return;
    area = cross_uv(cu[1] - cu[0], cv[1] - cv[0], cu[2] - cu[0], cv[2] - cv[0]);
    if (area == 0) return;
    pos  = area > 0;
    aabs = pos ? area : -area;
    umin = cu[0];
    umax = cu[0];
    vmin = cv[0];
    vmax = cv[0];
    for (k = 1; k < 3; k++) begin
      if (cu[k] < umin) umin = cu[k];
      if (cu[k] > umax) umax = cu[k];
      if (cv[k] < vmin) vmin = cv[k];
      if (cv[k] > vmax) vmax = cv[k];
    end
    umin = -((-umin) >>> FRAC_BITS);
    vmin = -((-vmin) >>> FRAC_BITS);
    umax = umax >>> FRAC_BITS;
    vmax = vmax >>> FRAC_BITS;
    nu = umax - umin + 1;
    nv = vmax - vmin + 1;
    if (nu <= 0 || nv <= 0) return;
    clip = (nu > SPAN) || (nv > SPAN);
    if (nu > SPAN) nu = SPAN;
    if (nv > SPAN) nv = SPAN;
    for (u = umin; u < umin + nu; u++) begin
      for (v = vmin; v < vmin + nv; v++) begin
        pu = u * UNIT;
        pv = v * UNIT;
        pt_in = 1'b1;
        for (k = 0; k < 3; k++) begin
          a = (k + 1) % 3;
          b = (k + 2) % 3;
          sub = cross_uv(cu[a] - pu, cv[a] - pv, cu[b] - pu, cv[b] - pv);
          // strictly inside: every sub-area has the sign of the whole
          if (pos ? (sub <= 0) : (sub >= 0)) pt_in = 1'b0;
          smag  = (sub < 0) ? -sub : sub;
          wt[k] = 17'((smag << 16) / aabs);
        end
        if (pt_in) begin
          h.data      = '0;
          h.data.pu   = u[15:0];
          h.data.pv   = v[15:0];
          h.data.face = c.face_id;
          h.data.w0   = wt[0];
          h.data.w1   = wt[1];
          h.data.w2   = wt[2];
          h.clipped   = clip;
          h.last      = 1'b0;
          found.push_back(h);
        end
      end
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) pending_hits.push_back(found[i]);
  endfunction

  function automatic corners_t mk(input real u0, input real v0, input real u1,
                                  input real v1, input real u2, input real v2,
                                  input logic [23:0] face);
    corners_t c;
    c.cu0     = $rtoi(u0 * 65536.0);
    c.cv0     = $rtoi(v0 * 65536.0);
    c.cu1     = $rtoi(u1 * 65536.0);
    c.cv1     = $rtoi(v1 * 65536.0);
    c.cu2     = $rtoi(u2 * 65536.0);
    c.cv2     = $rtoi(v2 * 65536.0);
    c.face_id = face;
    return c;
  endfunction

  function automatic void add_row(input corners_t c, input bit sel, input row_kind_e kind,
                                  input int pu = 0, input int pv = 0, input int w0 = 0,
                                  input int w1 = 0, input int w2 = 0);
    dir_row_t r;
    r.c                = c;
    r.sel              = sel;
    r.kind             = kind;
    r.hit.data         = '0;
    r.hit.data.pu      = pu[15:0];
    r.hit.data.pv      = pv[15:0];
    r.hit.data.face    = c.face_id;
    r.hit.data.w0      = w0[16:0];
    r.hit.data.w1      = w1[16:0];
    r.hit.data.w2      = w2[16:0];
    r.hit.clipped      = 1'b0;
    r.hit.last         = 1'b1;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] sat32(input longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // random triangle: mostly small ones near a lattice region, plus noise,
  // degenerate, oversized and unselected ones
  function automatic void roll_facet(output corners_t c, output bit sel);
    longint bu, bv, m;
    longint pu[3], pv[3];
    int     pick, reach, k;
    pick      = $urandom_range(99);
    c.face_id = 24'($urandom);
    sel       = (pick >= 8);
    if (pick < 20) begin
      c.cu0 = $urandom;
      c.cv0 = $urandom;
      c.cu1 = $urandom;
      c.cv1 = $urandom;
      c.cu2 = $urandom;
      c.cv2 = $urandom;
      return;
    end
    if ($urandom_range(99) < 85) begin
      bu = longint'($urandom_range(200)) - 100;
      bv = longint'($urandom_range(200)) - 100;
    end else begin
      bu = $urandom_range(1) ? 32760 : -32768;
      bv = $urandom_range(1) ? 32760 : -32768;
    end
    bu    = bu * UNIT + $urandom_range(UNIT - 1);
    bv    = bv * UNIT + $urandom_range(UNIT - 1);
    reach = (pick < 26) ? 40 : 4;
    for (k = 0; k < 3; k++) begin
      pu[k] = bu + longint'($urandom_range(2 * reach * UNIT)) - reach * UNIT;
      pv[k] = bv + longint'($urandom_range(2 * reach * UNIT)) - reach * UNIT;
    end
    if (pick >= 26 && pick < 32) begin
      // collinear or coincident corners
      m     = longint'($urandom_range(4)) - 2;
      pu[2] = pu[0] + m * (pu[1] - pu[0]);
      pv[2] = pv[0] + m * (pv[1] - pv[0]);
    end
    c.cu0 = sat32(pu[0]);
    c.cv0 = sat32(pv[0]);
    c.cu1 = sat32(pu[1]);
    c.cv1 = sat32(pv[1]);
    c.cu2 = sat32(pu[2]);
    c.cv2 = sat32(pv[2]);
  endfunction

  task automatic offer(input corners_t c, input bit sel);
    s_axis_tdata  <= c;
    s_axis_tuser  <= sel;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_offered++;
    if (sel) n_scanned++;
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_left  <= HOLD_CYCLES;
        hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      m_axis_tready <= (hold_left == 0) && !(hold_req && !hold_taken) &&
                       ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    lattice_hit_t want;
    hit_data_t    got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_hits.size() == 0) begin
        $error("unexpected lattice point u=%0d v=%0d face=%0d",
               $signed(got.pu), $signed(got.pv), got.face);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        check_field("point_u", $signed(want.data.pu), $signed(got.pu));
        check_field("point_v", $signed(want.data.pv), $signed(got.pv));
        check_field("face_out", want.data.face, got.face);
        check_field("weight0", want.data.w0, got.w0);
        check_field("weight1", want.data.w1, got.w1);
        check_field("weight2", want.data.w2, got.w2);
        check_field("pad", 0, got.pad);
        check_field("clipped", want.clipped, m_axis_tuser);
        check_field("last_point", want.last, m_axis_tlast);
        n_points++;
        if (m_axis_tuser) n_clipped++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no request moved for %0d cycles, %0d points outstanding",
                 quiet_cycles, pending_hits.size());
        $display("triangle_lattice_point_rasterizer_top regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    corners_t c;
    bit       sel;
    int       phase;
    int       n_random;
    n_random = 0;
    // not scanned
    add_row(mk(0, 0, 5, 0, 0, 5, 24'h00_0011), 1'b0, ROW_NONE);
    // one inside point, both windings, weights 1/3 each
    add_row(mk(0, 0, 3, 0, 0, 3, 24'h00_0005), 1'b1, ROW_ONE, 1, 1, 21845, 21845, 21845);
    add_row(mk(0, 0, 0, 3, 3, 0, 24'h00_0006), 1'b1, ROW_ONE, 1, 1, 21845, 21845, 21845);
    // collinear and coincident corners
    add_row(mk(0, 0, 1, 1, 2, 2, 24'h00_0007), 1'b1, ROW_NONE);
    add_row(mk(4.5, -2.25, 4.5, -2.25, 4.5, -2.25, 24'h00_0008), 1'b1, ROW_NONE);
    // lattice points only on the edges
    add_row(mk(0, 0, 2, 0, 0, 2, 24'h00_0009), 1'b1, ROW_NONE);
    // no lattice point in the box
    add_row(mk(0.25, 0.25, 0.75, 0.25, 0.25, 0.75, 24'h00_000a), 1'b1, ROW_NONE);
    add_row(mk(1, 1, 4, 1, 1, 4, 24'h00_0000), 1'b1, ROW_MODEL);
    add_row(mk(-0.5, -0.5, 7.5, -0.5, -0.5, 7.5, 24'h12_3456), 1'b1, ROW_MODEL);
    add_row(mk(-0.5, -0.5, 8.5, -0.5, -0.5, 8.5, 24'h65_4321), 1'b1, ROW_MODEL);
    // full 8 by 8 box inside: most results per triangle
    add_row(mk(-0.5, -0.5, 30, -0.5, -0.5, 30, 24'hab_cdef), 1'b1, ROW_MODEL);
    add_row(mk(0, 0, 20, 0, 0, 20, 24'h00_00ff), 1'b1, ROW_MODEL);
    add_row(mk(-5.5, -3.25, -1.75, -7.5, -0.5, -0.5, 24'h80_0000), 1'b1, ROW_MODEL);
    add_row(mk(0, 0, 8, 1, 7, 1.0625, 24'h7f_ffff), 1'b1, ROW_MODEL);
    // coordinate extremes
    add_row(mk(-32768, -32768, 32767 + 65535.0 / 65536.0, -32768, -32768,
               32767 + 65535.0 / 65536.0, 24'hff_ffff), 1'b1, ROW_MODEL);
    add_row(mk(32760, 32760, 32767 + 65535.0 / 65536.0, 32760, 32760,
               32767 + 65535.0 / 65536.0, 24'hff_fffe), 1'b1, ROW_MODEL);
    add_row(mk(32767 + 65535.0 / 65536.0, 32767 + 65535.0 / 65536.0, 32760.25, 32767.5,
               32766.5, 32759.75, 24'h00_0001), 1'b1, ROW_MODEL);
    add_row(mk(-32768, -32768, -32760.5, -32768, -32768, -32761.25, 24'h55_aa55),
            1'b1, ROW_MODEL);
    add_row(mk(-32768, 32767 + 65535.0 / 65536.0, 32767 + 65535.0 / 65536.0, -32768,
               32767 + 65535.0 / 65536.0, 32767 + 65535.0 / 65536.0, 24'haa_55aa),
            1'b1, ROW_MODEL);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].c, dir_rows[i].sel);
      case (dir_rows[i].kind)
        ROW_MODEL: raster_hits(dir_rows[i].c, dir_rows[i].sel);
        ROW_ONE:   pending_hits.push_back(dir_rows[i].hit);
        default:   ;
      endcase
      sender_gap();
    end

    // the sender keeps offering during the hold-off so the block backs up
    hold_req <= 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      phase     = n_random * 4 / RANDOM_ITEMS;
      idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 23 : 0;
      stall_pct <= (phase == 2) ? 45 : (phase == 3) ? 23 : 0;
      roll_facet(c, sel);
      offer(c, sel);
      raster_hits(c, sel);
      n_random++;
      sender_gap();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d triangles sent (%0d selected), %0d lattice points checked, %0d clipped",
             n_offered, n_scanned, n_points, n_clipped);
    $display("idle mixes: none, sender, receiver, both; one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("triangle_lattice_point_rasterizer_top regression: pass");
    else
      $display("triangle_lattice_point_rasterizer_top regression: fail");
    $finish;
  end

endmodule

@@ triangle_lattice_point_rasterizer_top.f @@
sv/tlpr_pkg.sv
sv/triangle_lattice_point_rasterizer_top.sv
sv/tlpr_checker.sv
verif/triangle_lattice_point_rasterizer_top_tb.sv
